/* rtl/sea_pkg.sv */
// types, constants and helpers shared by the static exciter regulator core
// no dependencies
package sea_pkg;

    localparam int COEF_BITS  = 16;
    localparam int COEF_ONE   = 65536;
    localparam int SIG_W      = 32;
    localparam int MA_W       = 33;   // multiplier a operand, signed
    localparam int MB_W       = 48;   // full b operand, signed
    localparam int CH_W       = 24;   // b chunk per multiplier pass
    localparam int MP_W       = MA_W + CH_W + 1;
    localparam int ACC_W      = 82;
    localparam int SAT_W      = 68;
    localparam int DIV_STEPS  = 48;
    localparam int ROOT_STEPS = 32;
    localparam int CNT_W      = 6;

    typedef enum logic [2:0] {
        CFG_TRANSDUCER_RATE = 3'd0,
        CFG_LAG_RATE        = 3'd1,
        CFG_EXCITER_RATE    = 3'd2,
        CFG_LEAD_RATIO      = 3'd3,
        CFG_EXCITER_GAIN    = 3'd4,
        CFG_WINDUP_GAIN     = 3'd5,
        CFG_FIELD_MAX       = 3'd6,
        CFG_FIELD_MIN       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_itr_req;

    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh7FFF_FFFF);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sh8000_0000);

    function automatic logic signed [SIG_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [SIG_W-1:0] y;
        if (x > SAT_MAX) begin
            y = SIG_W'(SAT_MAX);
        end else if (x < SAT_MIN) begin
            y = SIG_W'(SAT_MIN);
        end else begin
            y = x[SIG_W-1:0];
        end
        return y;
    endfunction

endpackage

/* rtl/sea_mul.sv */
// registered signed multiplier, one chunk of a wide product per cycle
// depends on sea_pkg
module sea_mul import sea_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [MA_W-1:0]  i_a,
    input  logic signed [CH_W:0]    i_b,
    output logic signed [MP_W-1:0]  o_p
);
    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MP_W'(i_a * i_b);
    end

    assign o_p = r_p;
endmodule

/* rtl/sea_itr.sv */
// shared shift-subtract unit: integer square root (2 bits a step)
// or unsigned restoring division (1 bit a step); depends on sea_pkg
module sea_itr import sea_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_itr_req    i_req,
    input  logic [63:0] i_operand,
    input  logic [25:0] i_divisor,
    output logic        o_done,
    output logic [47:0] o_result
);
    logic             r_busy;
    logic             r_done;
    logic             r_is_div;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_src;
    logic [34:0]      r_rem;
    logic [47:0]      r_q;
    logic [25:0]      r_dvs;

    logic [34:0] w_cand;
    logic [34:0] w_sub;
    logic [35:0] w_diff;
    logic        w_ge;

    always_comb begin
        if (r_is_div) begin
            w_cand = {r_rem[33:0], r_src[63]};
            w_sub  = {9'b0, r_dvs};
        end else begin
            w_cand = {r_rem[32:0], r_src[63:62]};
            w_sub  = {1'b0, r_q[31:0], 2'b01};
        end
        w_diff = {1'b0, w_cand} - {1'b0, w_sub};
        w_ge   = ~w_diff[35];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_is_div <= i_req.is_div;
            r_cnt    <= i_req.is_div ? CNT_W'(DIV_STEPS) : CNT_W'(ROOT_STEPS);
            r_src    <= i_operand;
            r_rem    <= '0;
            r_q      <= '0;
            r_dvs    <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_src <= r_is_div ? {r_src[62:0], 1'b0} : {r_src[61:0], 2'b00};
            r_rem <= w_ge ? w_diff[34:0] : w_cand;
            r_q   <= {r_q[46:0], w_ge};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_q;
endmodule

/* rtl/static_exciter_avr_step_core.sv */
// static exciter voltage regulator core: sequencer, state and config registers
// depends on sea_pkg, sea_mul, sea_itr
//
// One transaction at a time. An init transaction (operation 0) checks the field
// voltage against the limits. When it is in range and the gain is not zero, the
// core divides it by the gain on the shift-subtract unit and loads the regulator
// state; with a zero gain it loads the state directly. The divide takes 48 steps.
// A step transaction (operation 1) runs nine products on one shared multiplier.
// Each product is taken in two 24-bit halves of the signal operand, then a post
// step. The step also runs a square root on the shift-subtract unit in 32 steps.
// The input is ready only while the core is idle. The result sits in an output
// register, so the next transaction can be taken while it waits. Configuration
// writes are taken in any cycle and must only be made while the core is idle.
module static_exciter_avr_step_core import sea_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wr_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic signed [31:0] i_vd,
    input  logic signed [31:0] i_vq,
    input  logic signed [31:0] i_stabilizer_signal,
    input  logic signed [31:0] i_init_voltage,
    input  logic signed [31:0] i_init_field,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_field_voltage,
    output logic               o_init_error
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_POST = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // product sequence of a step
    typedef enum logic [3:0] {
        OP_VD = 4'd0,   // vd squared
        OP_VQ = 4'd1,   // plus vq squared
        OP_TR = 4'd2,   // transducer lag
        OP_LL = 4'd3,   // lead-lag state
        OP_CA = 4'd4,   // lead part
        OP_CB = 4'd5,   // plus lag part
        OP_WU = 4'd6,   // anti-windup feedback
        OP_KA = 4'd7,   // gain
        OP_ER = 4'd8    // exciter lag
    } t_mop;

    // config registers
    logic [16:0]        r_rate_t, r_rate_l, r_rate_e;
    logic [20:0]        r_ca;
    logic [25:0]        r_ka;
    logic [22:0]        r_kbc;
    logic signed [31:0] r_fmax, r_fmin;

    // regulator state
    logic signed [31:0] r_tr, r_xb, r_fu, r_fl, r_vref;
    logic signed [31:0] n_tr, n_xb, n_fu, n_fl, n_vref;

    // control
    t_state     r_state, n_state;
    t_mop       r_op, n_op;
    logic [1:0] r_ph, n_ph;
    logic       r_err, n_err;
    logic       r_out_valid, n_out_valid;
    logic signed [31:0] r_out_field, n_out_field;
    logic       r_out_err, n_out_err;

    // latched transaction and scratch
    logic               r_is_step;
    logic signed [31:0] r_vd, r_vq, r_pss, r_iv, r_if;
    logic signed [31:0] r_vh, n_vh, r_vin, n_vin, r_ve, n_ve;
    logic signed [31:0] r_tr_nx, n_tr_nx, r_ll_nx, n_ll_nx;
    logic signed [MB_W-1:0]  r_tmp, n_tmp;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    // shared units
    logic signed [MA_W-1:0]  w_ma;
    logic signed [MB_W-1:0]  w_mb;
    logic signed [CH_W:0]    w_mchunk;
    logic signed [MP_W-1:0]  w_mp;
    logic                    w_clr;
    t_itr_req                w_req;
    logic [63:0]             w_itr_opnd;
    logic                    w_itr_done;
    logic [47:0]             w_itr_res;

    logic signed [ACC_W-1:0] w_acc_sh;
    logic signed [31:0]      w_fu_new;
    logic signed [31:0]      w_vin_init;
    logic signed [48:0]      w_q49;
    logic [31:0]             w_abs_if;
    logic                    w_in_acc;

    assign w_in_acc = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_t <= 17'd65536;
            r_rate_l <= 17'd655;
            r_rate_e <= 17'd655;
            r_ca     <= 21'd6554;
            r_ka     <= 26'd13107200;
            r_kbc    <= 23'd0;
            r_fmax   <= 32'sd327680;
            r_fmin   <= -32'sd327680;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_TRANSDUCER_RATE: r_rate_t <= i_cfg_wr_data[16:0];
                CFG_LAG_RATE:        r_rate_l <= i_cfg_wr_data[16:0];
                CFG_EXCITER_RATE:    r_rate_e <= i_cfg_wr_data[16:0];
                CFG_LEAD_RATIO:      r_ca     <= i_cfg_wr_data[20:0];
                CFG_EXCITER_GAIN:    r_ka     <= i_cfg_wr_data[25:0];
                CFG_WINDUP_GAIN:     r_kbc    <= i_cfg_wr_data[22:0];
                CFG_FIELD_MAX:       r_fmax   <= $signed(i_cfg_wr_data);
                CFG_FIELD_MIN:       r_fmin   <= $signed(i_cfg_wr_data);
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        w_clr = 1'b1;
        unique case (r_op)
            OP_VD: begin
                w_ma = MA_W'(r_vd);
                w_mb = MB_W'(r_vd);
            end
            OP_VQ: begin
                w_ma  = MA_W'(r_vq);
                w_mb  = MB_W'(r_vq);
                w_clr = 1'b0;
            end
            OP_TR: begin
                w_ma = $signed({16'b0, r_rate_t});
                w_mb = MB_W'(MA_W'(r_vh) - MA_W'(r_tr));
            end
            OP_LL: begin
                w_ma = $signed({16'b0, r_rate_l});
                w_mb = MB_W'(MA_W'(r_vin) - MA_W'(r_xb));
            end
            OP_CA: begin
                w_ma = $signed({12'b0, r_ca});
                w_mb = MB_W'(r_vin);
            end
            OP_CB: begin
                // complement of the lead ratio, may go negative
                w_ma  = MA_W'(COEF_ONE) - $signed({12'b0, r_ca});
                w_mb  = MB_W'(r_xb);
                w_clr = 1'b0;
            end
            OP_WU: begin
                w_ma = $signed({10'b0, r_kbc});
                w_mb = MB_W'(MA_W'(r_fu) - MA_W'(r_fl));
            end
            OP_KA: begin
                w_ma = $signed({7'b0, r_ka});
                w_mb = MB_W'(r_ve);
            end
            OP_ER: begin
                w_ma = $signed({16'b0, r_rate_e});
                w_mb = r_tmp;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        // low half unsigned first, then the signed high half
        if (r_ph == 2'd0) begin
            w_mchunk = $signed({1'b0, w_mb[CH_W-1:0]});
        end else begin
            w_mchunk = $signed({w_mb[MB_W-1], w_mb[MB_W-1:CH_W]});
        end
    end

    sea_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mchunk),
        .o_p   (w_mp)
    );

    // root unit request: sqrt after the squares, divide on an in-range init with a nonzero gain
    assign w_abs_if = r_if[31] ? 32'(-r_if) : 32'(r_if);
    always_comb begin
        w_req.start  = 1'b0;
        w_req.is_div = 1'b0;
        w_itr_opnd   = r_acc[63:0];
        if (r_state == S_POST && r_op == OP_VQ) begin
            w_req.start = 1'b1;
        end
        if (r_state == S_INIT) begin
            w_req.is_div = 1'b1;
            w_itr_opnd   = {w_abs_if, 32'b0};
            w_req.start  = !(r_if > r_fmax || r_if < r_fmin) && (r_ka != '0);
        end
    end

    sea_itr u_itr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_operand (w_itr_opnd),
        .i_divisor (r_ka),
        .o_done    (w_itr_done),
        .o_result  (w_itr_res)
    );

    // floor shift of the accumulated product
    assign w_acc_sh = r_acc >>> COEF_BITS;
    assign w_fu_new = sat32(SAT_W'(r_fu) + SAT_W'(w_acc_sh));
    // quotient takes the sign of the field, truncation toward zero
    assign w_q49      = $signed({1'b0, w_itr_res});
    assign w_vin_init = sat32(r_if[31] ? SAT_W'(-w_q49) : SAT_W'(w_q49));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ph        = r_ph;
        n_err       = r_err;
        n_tr        = r_tr;
        n_xb        = r_xb;
        n_fu        = r_fu;
        n_fl        = r_fl;
        n_vref      = r_vref;
        n_vh        = r_vh;
        n_vin       = r_vin;
        n_ve        = r_ve;
        n_tr_nx     = r_tr_nx;
        n_ll_nx     = r_ll_nx;
        n_tmp       = r_tmp;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_field = r_out_field;
        n_out_err   = r_out_err;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op    = OP_VD;
                    n_ph    = 2'd0;
                    n_state = i_operation ? S_MUL : S_INIT;
                end
            end
            S_INIT: begin
                n_err = 1'b0;
                if (r_if > r_fmax || r_if < r_fmin) begin
                    // refused init, state held
                    n_err   = 1'b1;
                    n_state = S_DONE;
                end else if (r_ka == '0) begin
                    n_fu    = r_if;
                    n_fl    = r_if;
                    n_tr    = r_iv;
                    n_xb    = '0;
                    n_vref  = r_iv;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_itr_done) begin
                    n_fu    = r_if;
                    n_fl    = r_if;
                    n_tr    = r_iv;
                    n_xb    = w_vin_init;
                    n_vref  = sat32(SAT_W'(w_vin_init) + SAT_W'(r_iv));
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                // product of a pass is back in the cycle after issue
                unique case (r_ph)
                    2'd0: n_ph = 2'd1;
                    2'd1: begin
                        n_acc = (w_clr ? '0 : r_acc) + ACC_W'(w_mp);
                        n_ph  = 2'd2;
                    end
                    2'd2: begin
                        n_acc   = r_acc + (ACC_W'(w_mp) <<< CH_W);
                        n_ph    = 2'd0;
                        n_state = S_POST;
                    end
                    default: n_ph = 2'd0;
                endcase
            end
            S_POST: begin
                n_state = S_MUL;
                unique case (r_op)
                    OP_VD: n_op = OP_VQ;
                    OP_VQ: n_state = S_ROOT;
                    OP_TR: begin
                        n_tr_nx = sat32(SAT_W'(r_tr) + SAT_W'(w_acc_sh));
                        n_vin   = sat32(SAT_W'(r_vref) - SAT_W'(r_tr) + SAT_W'(r_pss));
                        n_op    = OP_LL;
                    end
                    OP_LL: begin
                        n_ll_nx = sat32(SAT_W'(r_xb) + SAT_W'(w_acc_sh));
                        n_op    = OP_CA;
                    end
                    OP_CA: n_op = OP_CB;
                    OP_CB: begin
                        n_tmp = MB_W'(w_acc_sh);
                        n_op  = OP_WU;
                    end
                    OP_WU: begin
                        n_ve = sat32(SAT_W'(r_tmp) - SAT_W'(w_acc_sh));
                        n_op = OP_KA;
                    end
                    OP_KA: begin
                        n_tmp = MB_W'(w_acc_sh - ACC_W'(r_fu));
                        n_op  = OP_ER;
                    end
                    OP_ER: begin
                        n_fu = w_fu_new;
                        // upper limit wins when the limits cross
                        if (w_fu_new > r_fmax) begin
                            n_fl = r_fmax;
                        end else if (w_fu_new < r_fmin) begin
                            n_fl = r_fmin;
                        end else begin
                            n_fl = w_fu_new;
                        end
                        n_tr    = r_tr_nx;
                        n_xb    = r_ll_nx;
                        n_err   = 1'b0;
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ROOT: begin
                if (w_itr_done) begin
                    n_vh    = w_itr_res[31] ? 32'sh7FFF_FFFF : $signed(w_itr_res[31:0]);
                    n_op    = OP_TR;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_field = r_fl;
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_VD;
            r_ph        <= 2'd0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_tr        <= '0;
            r_xb        <= '0;
            r_fu        <= '0;
            r_fl        <= '0;
            r_vref      <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_ph        <= n_ph;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            r_tr        <= n_tr;
            r_xb        <= n_xb;
            r_fu        <= n_fu;
            r_fl        <= n_fl;
            r_vref      <= n_vref;
        end
    end

    // payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_out_field <= n_out_field;
        r_out_err   <= n_out_err;
        r_vh        <= n_vh;
        r_vin       <= n_vin;
        r_ve        <= n_ve;
        r_tr_nx     <= n_tr_nx;
        r_ll_nx     <= n_ll_nx;
        r_tmp       <= n_tmp;
        r_acc       <= n_acc;
        if (w_in_acc) begin
            r_is_step <= i_operation;
            r_vd      <= i_vd;
            r_vq      <= i_vq;
            r_pss     <= i_stabilizer_signal;
            r_iv      <= i_init_voltage;
            r_if      <= i_init_field;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_field_voltage = r_out_field;
    assign o_init_error    = r_out_err;

    // the root unit only finishes while the sequencer waits on it
    a_itr_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_itr_done |-> (r_state == S_ROOT || r_state == S_DIV))
        else $error("root unit finished outside a wait state");

    // a step transaction never waits on the divider, an init never multiplies
    a_path_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV |-> !r_is_step) and (r_state == S_MUL |-> r_is_step))
        else $error("sequencer on the wrong path for the transaction");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input ready right after a transaction");

    // a finished transaction lands in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=> r_out_valid)
        else $error("result not presented");
endmodule

/* dv/static_exciter_avr_step_core_tb.sv */
// testbench for the static exciter voltage regulator core
// depends on sea_pkg and static_exciter_avr_step_core; drives init and step
// transactions and checks field voltage and error flag against an in-bench predictor
`timescale 1ns / 1ps

module static_exciter_avr_step_core_tb;
    import sea_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 100;
    localparam bit OP_INIT = 1'b0;
    localparam bit OP_STEP = 1'b1;

    typedef struct {
        logic signed [31:0] field;
        logic               err;
    } t_field_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_addr = '0;
    logic [31:0]        i_cfg_wr_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_operation = 1'b0;
    logic signed [31:0] i_vd = '0;
    logic signed [31:0] i_vq = '0;
    logic signed [31:0] i_stabilizer_signal = '0;
    logic signed [31:0] i_init_voltage = '0;
    logic signed [31:0] i_init_field = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_field_voltage;
    logic               o_init_error;

    static_exciter_avr_step_core dut (.*);

    always #4 i_clk = ~i_clk;

    // regulator copy: coefficient registers and loop state
    longint rate_tr, rate_lag, rate_exc, lead_ca, gain_ka, gain_kbc, lim_max, lim_min;
    longint st_vr, st_xb, st_ef_unl, st_ef_lim, st_vref;

    t_field_result field_expq[$];
    int  mismatch_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  idle_cycles = 0;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // q16 product rescale, rounding toward minus infinity
    function automatic longint q16(longint x);
        return x >>> COEF_BITS;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // advance the regulator copy by one transaction
    function automatic t_field_result regulate(bit op, longint vd, longint vq, longint pss,
                                               longint vinit, longint efinit);
        t_field_result r;
        longint unsigned md, mq, rt;
        longint vh, vr_prev, xb_prev, vin, acc, drive;
        r.err = 1'b0;
        if (op == OP_INIT) begin
            if (efinit > lim_max || efinit < lim_min) begin
                r.err = 1'b1;
            end else begin
                vin = 0;
                if (gain_ka != 0) vin = clip32((efinit * COEF_ONE) / gain_ka);
                st_ef_unl = efinit;
                st_ef_lim = efinit;
                st_vr = vinit;
                st_xb = vin;
                st_vref = clip32(vin + vinit);
            end
        end else begin
            md = abs64(vd);
            mq = abs64(vq);
            rt = root64(md * md + mq * mq);
            vh = (rt > 64'd2147483647) ? 64'sd2147483647 : longint'(rt);
            vr_prev = st_vr;
            xb_prev = st_xb;
            st_vr = clip32(vr_prev + q16(rate_tr * (vh - vr_prev)));
            vin = clip32(st_vref - vr_prev + pss);
            st_xb = clip32(xb_prev + q16(rate_lag * (vin - xb_prev)));
            acc = q16(vin * lead_ca + xb_prev * (COEF_ONE - lead_ca));
            acc = acc - q16(gain_kbc * (st_ef_unl - st_ef_lim));
            acc = clip32(acc);
            drive = q16(gain_ka * acc) - st_ef_unl;
            st_ef_unl = clip32(st_ef_unl + q16(rate_exc * drive));
            // upper limit wins when the limits are crossed
            if (st_ef_unl > lim_max) st_ef_lim = lim_max;
            else if (st_ef_unl < lim_min) st_ef_lim = lim_min;
            else st_ef_lim = st_ef_unl;
        end
        r.field = st_ef_lim[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // config write, only while the core is idle
    task automatic cfg_write(t_cfg_idx idx, longint val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= val[31:0];
        case (idx)
            CFG_TRANSDUCER_RATE: rate_tr  = val & 64'h1FFFF;
            CFG_LAG_RATE:        rate_lag = val & 64'h1FFFF;
            CFG_EXCITER_RATE:    rate_exc = val & 64'h1FFFF;
            CFG_LEAD_RATIO:      lead_ca  = val & 64'h1FFFFF;
            CFG_EXCITER_GAIN:    gain_ka  = val & 64'h3FFFFFF;
            CFG_WINDUP_GAIN:     gain_kbc = val & 64'h7FFFFF;
            CFG_FIELD_MAX:       lim_max  = longint'($signed(val[31:0]));
            CFG_FIELD_MIN:       lim_min  = longint'($signed(val[31:0]));
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // one transaction on the input channel; entered and left at a rising edge
    task automatic send_item(bit op, longint vd, longint vq, longint pss,
                             longint vinit, longint efinit);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_operation         <= op;
        i_vd                <= vd[31:0];
        i_vq                <= vq[31:0];
        i_stabilizer_signal <= pss[31:0];
        i_init_voltage      <= vinit[31:0];
        i_init_field        <= efinit[31:0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        field_expq.push_back(regulate(op, vd, vq, pss, vinit, efinit));
    endtask

    // hold off until every expected field voltage has come back
    task automatic drain;
        i_in_valid <= 1'b0;
        while (field_expq.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic longint rand_sig();
        case ($urandom_range(3))
            0: return longint'($signed($urandom()));
            1: return longint'($signed($urandom_range(32'h40000))) - 64'sh20000;
            2: return longint'($urandom_range(32'h1FFFF));
            default: return longint'($signed($urandom_range(32'hFFFFF))) - 64'sh80000;
        endcase
    endfunction

    function automatic longint field_in_limits();
        longint span;
        if (lim_min > lim_max) return lim_max;
        span = lim_max - lim_min + 1;
        return lim_min + longint'({$urandom(), $urandom()} % span);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker: each output transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_field_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (field_expq.size() == 0) begin
                report_mismatch("unexpected transaction", o_field_voltage, 0);
            end else begin
                want = field_expq.pop_front();
                if (o_field_voltage !== want.field)
                    report_mismatch("field_voltage", o_field_voltage, want.field);
                if (o_init_error !== want.err)
                    report_mismatch("init_error", o_init_error, want.err);
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // defaults, refused inits on both limits, extreme voltages and stabilizer
    task automatic test_directed;
        send_item(OP_STEP, 0, 0, 0, 0, 0);
        send_item(OP_INIT, 0, 0, 0, 64'sh10000, 64'sh20000);
        send_item(OP_STEP, 64'sh10000, 0, 0, 0, 0);
        send_item(OP_STEP, 64'sh7FFFFFFF, 64'sh7FFFFFFF, 0, 0, 0);
        send_item(OP_STEP, -64'sh80000000, -64'sh80000000, 64'sh7FFFFFFF, 0, 0);
        send_item(OP_STEP, -64'sh80000000, 64'sh7FFFFFFF, -64'sh80000000, 0, 0);
        send_item(OP_INIT, 0, 0, 0, 0, lim_max + 1);
        send_item(OP_INIT, 0, 0, 0, 0, lim_min - 1);
        send_item(OP_INIT, 0, 0, 0, 64'sh7FFFFFFF, lim_max);
        send_item(OP_STEP, 64'shFFFF, -64'sh1, 64'sh7FFFFFFF, 0, 0);
        send_item(OP_INIT, 0, 0, 0, -64'sh80000000, lim_min);
        send_item(OP_STEP, 1, -1, -64'sh80000000, 0, 0);
        send_item(OP_INIT, 0, 0, 0, 64'sh7FFFFFFF, -64'sh80000000);
        send_item(OP_INIT, 0, 0, 0, 64'sh10000, 64'sh7FFFFFFF);
        drain();
    endtask

    // register extremes: zero gain, lead ratio of one, crossed and wide limits
    task automatic test_config_extremes;
        cfg_write(CFG_TRANSDUCER_RATE, 0);
        cfg_write(CFG_LAG_RATE, 65536);
        cfg_write(CFG_EXCITER_RATE, 65536);
        cfg_write(CFG_LEAD_RATIO, 65536);
        cfg_write(CFG_EXCITER_GAIN, 0);
        cfg_write(CFG_WINDUP_GAIN, 6553600);
        cfg_write(CFG_FIELD_MAX, 64'sh7FFFFFFF);
        cfg_write(CFG_FIELD_MIN, -64'sh80000000);
        send_item(OP_INIT, 0, 0, 0, 64'sh10000, 64'sh30000);
        send_item(OP_STEP, 64'sh7FFFFFFF, 0, 64'sh7FFFFFFF, 0, 0);
        send_item(OP_STEP, 0, 64'sh7FFFFFFF, 0, 0, 0);
        drain();
        cfg_write(CFG_EXCITER_GAIN, 65536000);
        cfg_write(CFG_LEAD_RATIO, 1048576);
        cfg_write(CFG_TRANSDUCER_RATE, 65536);
        cfg_write(CFG_FIELD_MAX, -64'sh10000);
        cfg_write(CFG_FIELD_MIN, 64'sh10000);
        send_item(OP_INIT, 0, 0, 0, 0, 0);
        send_item(OP_STEP, 64'sh20000, 0, 64'sh7FFFFFFF, 0, 0);
        send_item(OP_STEP, 0, 0, -64'sh80000000, 0, 0);
        send_item(OP_STEP, 64'sh8000, 64'sh8000, 0, 0, 0);
        drain();
        cfg_write(CFG_EXCITER_GAIN, 1);
        cfg_write(CFG_LEAD_RATIO, 0);
        cfg_write(CFG_WINDUP_GAIN, 0);
        cfg_write(CFG_EXCITER_RATE, 0);
        cfg_write(CFG_LAG_RATE, 0);
        cfg_write(CFG_FIELD_MAX, 64'sh50000);
        cfg_write(CFG_FIELD_MIN, -64'sh50000);
        send_item(OP_INIT, 0, 0, 0, 64'sh10000, 64'sh40000);
        send_item(OP_STEP, 64'sh10000, 64'sh10000, 64'sh1000, 0, 0);
        drain();
    endtask

    // random settings, an init within the limits where they do not cross, then mostly steps with some inits
    task automatic test_random_phase(int n_items, int s_idle, int r_stall);
        int sel;
        longint lim_a, lim_b;
        drain();
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        cfg_write(CFG_TRANSDUCER_RATE, $urandom_range(65536));
        cfg_write(CFG_LAG_RATE, $urandom_range(65536));
        cfg_write(CFG_EXCITER_RATE, $urandom_range(65536));
        cfg_write(CFG_LEAD_RATIO, $urandom_range(1048576));
        cfg_write(CFG_EXCITER_GAIN, $urandom_range(65536000, 1));
        cfg_write(CFG_WINDUP_GAIN, $urandom_range(6553600));
        if ($urandom_range(3) == 0) begin
            lim_a = longint'($signed($urandom()));
            lim_b = longint'($signed($urandom()));
        end else begin
            lim_a = longint'($urandom_range(32'h640000, 32'h10000));
            lim_b = -longint'($urandom_range(32'h640000, 32'h10000));
        end
        cfg_write(CFG_FIELD_MAX, lim_a);
        cfg_write(CFG_FIELD_MIN, lim_b);
        send_item(OP_INIT, rand_sig(), rand_sig(), rand_sig(), rand_sig(), field_in_limits());
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(99);
            if (sel < 90)
                send_item(OP_STEP, rand_sig(), rand_sig(), rand_sig(), rand_sig(), rand_sig());
            else if (sel < 95)
                send_item(OP_INIT, rand_sig(), rand_sig(), rand_sig(), rand_sig(),
                          field_in_limits());
            else
                send_item(OP_INIT, rand_sig(), rand_sig(), rand_sig(),
                          longint'($signed($urandom())), longint'($signed($urandom())));
        end
    endtask

    initial begin
        rate_tr = 65536;  rate_lag = 655;  rate_exc = 655;  lead_ca = 6554;
        gain_ka = 13107200;  gain_kbc = 0;  lim_max = 327680;  lim_min = -327680;
        st_vr = 0;  st_xb = 0;  st_ef_unl = 0;  st_ef_lim = 0;  st_vref = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct  = 30;
        recv_stall_pct = 71;
        test_directed();
        test_config_extremes();
        test_random_phase(130, 30, 71);
        test_random_phase(130, 71, 30);
        test_random_phase(130, 0, 0);
        drain();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sea_pkg.sv
rtl/sea_mul.sv
rtl/sea_itr.sv
rtl/static_exciter_avr_step_core.sv
dv/static_exciter_avr_step_core_tb.sv
